>>> src/crc8h74_pkg.sv
// crc8h74_pkg: shared constants and functions for the crc-8 / hamming(7,4) codec
// holds the crc-8 fold table and the per-nibble hamming encode and correct logic
// no dependencies
package crc8h74_pkg;

  localparam int MSG_W  = 16;
  localparam int CRC_W  = 8;
  localparam int WORD_W = MSG_W + CRC_W;
  localparam int NIB_N  = WORD_W / 4;
  localparam int CODE_W = NIB_N * 7;

  localparam logic REQ_ENCODE = 1'b0;
  localparam logic REQ_DECODE = 1'b1;

  // syndrome codes that point at a data bit
  localparam logic [2:0] SYN_D3 = 3'd3;
  localparam logic [2:0] SYN_D0 = 3'd5;
  localparam logic [2:0] SYN_D1 = 3'd6;
  localparam logic [2:0] SYN_D2 = 3'd7;

  // x^(8+i) mod x^8+x^2+x+1
  localparam logic [CRC_W-1:0] CRC_FOLD [MSG_W] = '{
    8'h07, 8'h0E, 8'h1C, 8'h38, 8'h70, 8'hE0, 8'hC7, 8'h89,
    8'h15, 8'h2A, 8'h54, 8'hA8, 8'h57, 8'hAE, 8'h5B, 8'hB6
  };

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [MSG_W-1:0]  data;
    logic              err;
  } res_t;

  function automatic logic [CRC_W-1:0] crc_rem24(logic [WORD_W-1:0] v);
    logic [CRC_W-1:0] r;
    r = v[CRC_W-1:0];
    for (int i = 0; i < MSG_W; i++) begin
      if (v[CRC_W+i]) begin
        r = r ^ CRC_FOLD[i];
      end
    end
    return r;
  endfunction

  function automatic logic [6:0] ham_enc(logic [3:0] n);
    logic p0, p1, p2;
    p0 = n[3] ^ n[2] ^ n[1];
    p1 = n[2] ^ n[1] ^ n[0];
    p2 = n[3] ^ n[1] ^ n[0];
    return {n, p0, p1, p2};
  endfunction

  function automatic logic [3:0] ham_dec(logic [6:0] w);
    logic [2:0] s;
    logic [3:0] n;
    n = w[6:3];
    s = {w[2] ^ w[6] ^ w[5] ^ w[4],
         w[1] ^ w[5] ^ w[4] ^ w[3],
         w[0] ^ w[6] ^ w[4] ^ w[3]};
    case (s)
      SYN_D3:  n = n ^ 4'b0001;
      SYN_D0:  n = n ^ 4'b1000;
      SYN_D1:  n = n ^ 4'b0100;
      SYN_D2:  n = n ^ 4'b0010;
      default: n = n;
    endcase
    return n;
  endfunction

endpackage

>>> src/crc8_hamming74_codec.sv
// crc8_hamming74_codec: crc-8 plus hamming(7,4) encoder and decoder, top level
// depends on crc8h74_pkg for the fold table and hamming functions
//
// usage
//   input channel: in_valid / in_stall with req_type, data_in, code_in.
//   req_type low encodes data_in into a 42-bit code_out (crc-8 appended,
//   six hamming(7,4) words, first word in the msbs); req_type high
//   corrects code_in word by word, returns the 16 message bits on
//   data_out and raises crc_error on a nonzero crc remainder.
//   output channel: out_valid / out_stall with code_out, data_out, crc_error;
//   the field not used by the request reads zero.
//   each result is registered, in the result register or, while that is held, in the skid register.
//   throughput is one item per cycle while in_stall is low; the crc and hamming
//   logic between the input ports and the result register is combinational.
//   a two-entry result buffer (result register plus skid register) lets
//   an item be taken while the result waits; in_stall rises only when
//   both entries hold items, and drops as soon as the receiver takes one.
//   reset empties both entries; no item is lost or repeated under stall.
module crc8_hamming74_codec
  import crc8h74_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              req_type,
  input  logic [MSG_W-1:0]  data_in,
  input  logic [CODE_W-1:0] code_in,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CODE_W-1:0] code_out,
  output logic [MSG_W-1:0]  data_out,
  output logic              crc_error
);

  logic              out_vld;
  logic              skid_vld;
  res_t              out_res;
  res_t              skid_res;
  res_t              res_next;
  logic [WORD_W-1:0] enc_word;
  logic [WORD_W-1:0] dec_word;
  logic [CODE_W-1:0] enc_code;
  logic              in_take;
  logic              out_take;

  always_comb begin
    enc_word = {data_in, crc_rem24({data_in, {CRC_W{1'b0}}})};
    for (int i = 0; i < NIB_N; i++) begin
      enc_code[CODE_W-1-7*i -: 7] = ham_enc(enc_word[WORD_W-1-4*i -: 4]);
      dec_word[WORD_W-1-4*i -: 4] = ham_dec(code_in[CODE_W-1-7*i -: 7]);
    end
    if (req_type == REQ_ENCODE) begin
      res_next.code = enc_code;
      res_next.data = '0;
      res_next.err  = 1'b0;
    end else begin
      res_next.code = '0;
      res_next.data = dec_word[WORD_W-1 -: MSG_W];
      res_next.err  = |crc_rem24(dec_word);
    end
  end

  assign in_stall  = skid_vld;
  assign in_take   = in_valid && !skid_vld;
  assign out_take  = out_vld && !out_stall;
  assign out_valid = out_vld;
  assign code_out  = out_res.code;
  assign data_out  = out_res.data;
  assign crc_error = out_res.err;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld  <= 1'b0;
      skid_vld <= 1'b0;
    end else begin
      if (!out_vld || out_take) begin
        if (skid_vld) begin
          out_res  <= skid_res;
          out_vld  <= 1'b1;
          skid_vld <= 1'b0;
        end else begin
          out_res <= res_next;
          out_vld <= in_take;
        end
      end else if (in_take) begin
        skid_res <= res_next;
        skid_vld <= 1'b1;
      end
    end
  end

  // skid entry only fills behind a held result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_vld |-> out_vld)
    else $error("skid entry valid with empty result register");

  a_fill_skid: assert property (@(posedge clk) disable iff (rst)
    in_take && out_vld && out_stall |=> skid_vld)
    else $error("item taken under stall not kept in skid entry");

  a_skid_moves: assert property (@(posedge clk) disable iff (rst)
    out_take && skid_vld |=> out_vld && (out_res == $past(skid_res)))
    else $error("skid entry not moved to result register");

  a_error_decode_only: assert property (@(posedge clk) disable iff (rst)
    out_vld && crc_error |-> code_out == '0)
    else $error("crc error raised on an encode item");

endmodule

>>> tb/sv/tb_top.sv
// tb_top: self-checking bench for the crc-8 / hamming(7,4) codec, one item per handshake
// predicts every result with its own crc division and syndrome correction, checks in order
// depends on crc8h74_pkg and crc8_hamming74_codec

import crc8h74_pkg::*;

localparam logic [CRC_W:0] CRC_GEN = 9'h107;

function automatic logic [CRC_W-1:0] crc8_remainder(logic [WORD_W-1:0] v);
  for (int b = WORD_W - 1; b >= CRC_W; b--) begin
    if (v[b]) begin
      v[b -: CRC_W+1] = v[b -: CRC_W+1] ^ CRC_GEN;
    end
  end
  return v[CRC_W-1:0];
endfunction

function automatic logic [6:0] hamming_word(logic [3:0] n);
  return {n, n[3] ^ n[2] ^ n[1], n[2] ^ n[1] ^ n[0], n[3] ^ n[1] ^ n[0]};
endfunction

function automatic logic [2:0] hamming_syndrome(logic [6:0] w);
  logic [6:0] clean;
  clean = hamming_word(w[6:3]);
  return clean[2:0] ^ w[2:0];
endfunction

// flip the one bit whose single-error syndrome matches
function automatic logic [3:0] corrected_nibble(logic [6:0] w);
  logic [2:0] s;
  s = hamming_syndrome(w);
  for (int j = 0; j < 7; j++) begin
    if (s != 3'b000 && hamming_syndrome(7'b1 << j) == s) begin
      w[j] = ~w[j];
    end
  end
  return w[6:3];
endfunction

function automatic logic [CODE_W-1:0] codeword_for(logic [MSG_W-1:0] msg);
  logic [WORD_W-1:0] full;
  logic [CODE_W-1:0] cw;
  full = {msg, crc8_remainder({msg, 8'h00})};
  for (int i = 0; i < NIB_N; i++) begin
    cw[CODE_W-1-7*i -: 7] = hamming_word(full[WORD_W-1-4*i -: 4]);
  end
  return cw;
endfunction

function automatic res_t predict_result(logic rt, logic [MSG_W-1:0] d, logic [CODE_W-1:0] c);
  res_t r;
  logic [WORD_W-1:0] full;
  r = '0;
  if (rt == REQ_ENCODE) begin
    r.code = codeword_for(d);
  end else begin
    for (int i = 0; i < NIB_N; i++) begin
      full[WORD_W-1-4*i -: 4] = corrected_nibble(c[CODE_W-1-7*i -: 7]);
    end
    r.data = full[WORD_W-1:CRC_W];
    r.err  = |crc8_remainder(full);
  end
  return r;
endfunction

class codec_scoreboard;
  res_t pending_results[$];
  int   mismatch_count;
  int   results_seen;

  function void note_request(logic rt, logic [MSG_W-1:0] d, logic [CODE_W-1:0] c);
    pending_results.push_back(predict_result(rt, d, c));
  endfunction

  function void check_result(logic [CODE_W-1:0] code, logic [MSG_W-1:0] data, logic err);
    res_t want;
    results_seen++;
    if (pending_results.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("result %0d: nothing pending, got code %h data %h crc_error %b",
                 results_seen, code, data, err);
      end
      return;
    end
    want = pending_results.pop_front();
    if (want.code !== code || want.data !== data || want.err !== err) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("result %0d: expected code %h data %h err %b, got code %h data %h err %b",
                 results_seen, want.code, want.data, want.err, code, data, err);
      end
    end
  endfunction
endclass

module tb_top;

  localparam int IDLE_BY_PHASE  [4] = '{0, 67, 0, 6};
  localparam int STALL_BY_PHASE [4] = '{0, 0, 67, 6};
  localparam int ITEMS_PER_PHASE    = 238;

  logic              clk;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              req_type  = REQ_ENCODE;
  logic [MSG_W-1:0]  data_in   = '0;
  logic [CODE_W-1:0] code_in   = '0;
  logic              out_stall = 1'b0;
  logic              in_stall;
  logic              out_valid;
  logic [CODE_W-1:0] code_out;
  logic [MSG_W-1:0]  data_out;
  logic              crc_error;

  int idle_pct  = 0;
  int stall_pct = 0;

  codec_scoreboard sb = new();

  crc8_hamming74_codec u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .data_in   (data_in),
    .code_in   (code_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .code_out  (code_out),
    .data_out  (data_out),
    .crc_error (crc_error)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #3200000;
    $display("DONE: errors detected");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_result(code_out, data_out, crc_error);
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic send_item(input logic rt, input logic [MSG_W-1:0] d,
                           input logic [CODE_W-1:0] c);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      req_type <= 1'($urandom_range(1));
      data_in  <= MSG_W'($urandom);
      code_in  <= CODE_W'({$urandom, $urandom});
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rt;
    data_in  <= d;
    code_in  <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(rt, d, c);
  endtask

  // mostly codewords with a few bit errors, some encodes, some raw noise
  task automatic send_random_item();
    int pick;
    int flips;
    int idx;
    logic [MSG_W-1:0]  msg;
    logic [CODE_W-1:0] cw;
    pick = $urandom_range(99);
    msg  = MSG_W'($urandom);
    cw   = CODE_W'({$urandom, $urandom});
    if (pick < 25) begin
      send_item(REQ_ENCODE, msg, cw);
    end else if (pick < 90) begin
      cw    = codeword_for(msg);
      flips = $urandom_range(9);
      flips = (flips < 3) ? 0 : (flips < 7) ? 1 : flips - 5;
      repeat (flips) begin
        idx     = $urandom_range(CODE_W - 1);
        cw[idx] = ~cw[idx];
      end
      send_item(REQ_DECODE, MSG_W'($urandom), cw);
    end else begin
      send_item(REQ_DECODE, MSG_W'($urandom), cw);
    end
  endtask

  task automatic run_directed();
    logic [CODE_W-1:0] cw;
    send_item(REQ_ENCODE, 16'h0000, '0);
    send_item(REQ_ENCODE, 16'hFFFF, '1);
    send_item(REQ_ENCODE, 16'h8000, CODE_W'({$urandom, $urandom}));
    send_item(REQ_ENCODE, 16'h0001, CODE_W'({$urandom, $urandom}));
    send_item(REQ_ENCODE, 16'hA5C3, CODE_W'({$urandom, $urandom}));
    send_item(REQ_DECODE, 16'hFFFF, codeword_for(16'h0000));
    send_item(REQ_DECODE, MSG_W'($urandom), codeword_for(16'hFFFF));
    cw = codeword_for(16'h1234);
    // one error at each bit position of a word, spread over the words
    for (int b = 0; b < 7; b++) begin
      send_item(REQ_DECODE, MSG_W'($urandom), cw ^ (42'b1 << (7 * (b % 6) + b)));
    end
    // double error in one word miscorrects, crc should flag it
    send_item(REQ_DECODE, MSG_W'($urandom), cw ^ (42'h3 << 14));
    send_item(REQ_DECODE, MSG_W'($urandom), cw ^ (42'b1 << 40) ^ (42'b1 << 3));
    send_item(REQ_DECODE, MSG_W'($urandom), '0);
    send_item(REQ_DECODE, MSG_W'($urandom), '1);
    send_item(REQ_DECODE, 16'h0000, codeword_for(16'hFFFF) ^ (42'h7 << 21));
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = IDLE_BY_PHASE[ph];
      stall_pct <= STALL_BY_PHASE[ph];
      repeat (ITEMS_PER_PHASE) send_random_item();
    end
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> files.f
src/crc8h74_pkg.sv
src/crc8_hamming74_codec.sv
tb/sv/tb_top.sv
